// File: hw/rtl/midi_note_latch_core_macros.svh
// assertion macros used by the midi note latch checker
`ifndef MIDI_NOTE_LATCH_CORE_MACROS_SVH
`define MIDI_NOTE_LATCH_CORE_MACROS_SVH

// clocked assertion, switched off while reset is low
`define MNL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MNL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/mnl_pkg.sv
// types and constants of the midi note latch
`default_nettype none

package mnl_pkg;

  localparam int LIST_DEPTH_DEF = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MODE  = 1'd1;

  localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
  localparam logic [3:0] KIND_AFTERTOUCH = 4'hA;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_DROP,
    OP_CMD,
    OP_LATCH_ON,
    OP_LATCH_OFF,
    OP_TOGGLE_ON
  } op_e;

  // per-cell controls: take the neighbor's entry or load the current note
  typedef struct packed {
    logic take_l;
    logic take_h;
    logic load_l;
    logic load_h;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mnl_cell.sv
// one list cell: an entry of the latched list and one of the held list
`default_nettype none

module mnl_cell
  import mnl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [6:0] note_i,
  input  wire logic [6:0] nbr_l_i,
  input  wire logic [6:0] nbr_h_i,
  output logic      [6:0] latched_o,
  output logic      [6:0] held_o
);

  logic [6:0] l_q, l_d;
  logic [6:0] h_q, h_d;

  always_comb begin
    l_d = l_q;
    if (ctrl_i.load_l) begin
      l_d = note_i;
    end else if (ctrl_i.take_l) begin
      l_d = nbr_l_i;
    end
  end

  always_comb begin
    h_d = h_q;
    if (ctrl_i.load_h) begin
      h_d = note_i;
    end else if (ctrl_i.take_h) begin
      h_d = nbr_h_i;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= l_d;
    h_q <= h_d;
  end

  assign latched_o = l_q;
  assign held_o    = h_q;

endmodule

`default_nettype wire

// File: hw/rtl/midi_note_latch_core.sv
// midi note latch: a row of list cells driven by a scan sequencer
//
// Input channel: one MIDI packet per beat (command, status, two data bytes),
// taken when in_valid_i is high and in_stall_o low. Output channel: packets
// with last_of_run_o marking the final beat of each packet's run, taken when
// out_valid_o is high and out_stall_i low. Config: cfg_valid_i/cfg_ready_o
// writes latch_enable (index 0) or toggle_mode (index 1); always ready.
// Packets that pass straight through go to ST_FINISH without a scan; dropped
// ones are taken in ST_IDLE and give no output. Note messages in latch mode,
// note-ons in toggle mode and release commands rotate the whole cell row once
// to search both lists and to send released note-offs from the head cell. One
// packet is worked on at a time.
// A stalled receiver freezes the rotation while a release beat waits, and
// the final beat waits in the output register until taken.
// Reset empties both lists, clears the config registers and the release
// channel; list entries themselves are not cleared.
`default_nettype none

module midi_note_latch_core
  import mnl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 command_i,
  input  wire logic [7:0]           status_byte_i,
  input  wire logic [6:0]           data_one_i,
  input  wire logic [6:0]           data_two_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [7:0]           out_status_o,
  output logic      [6:0]           out_data_one_o,
  output logic      [6:0]           out_data_two_o,
  output logic                      last_of_run_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic                 cfg_data_i
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  state_e state_q, state_d;
  op_e    op_q, op_in;

  logic             rel_q, rel_in;
  logic [3:0]       relch_q;
  logic [CNT_W-1:0] lcount_q, lcount_d, hcount_q, hcount_d;
  logic [CNT_W-1:0] step_q;
  logic             lfound_q, hfound_q;
  logic [IDX_W-1:0] lpos_q, hpos_q;
  logic             latch_en_q, toggle_q;

  logic [7:0] status_q;
  logic [6:0] note_q, vel_q;

  logic       out_valid_q;
  logic [7:0] out_status_q, out_status_d;
  logic [6:0] out_d1_q, out_d1_d, out_d2_q, out_d2_d;
  logic       out_last_q, out_last_d;
  logic       out_load;

  logic             out_free, in_accept;
  logic             l_in_range, h_in_range, rel_emit;
  logic             scan_go, scan_last, fin_emit, fin_go;
  logic             ap_l, ap_h, rm_l, rm_h;
  logic [IDX_W-1:0] lidx, hidx;
  logic [CNT_W-1:0] lbase, hbase;

  logic [3:0] kind;
  logic       is_on, is_note;

  logic [6:0] latched_w [LIST_DEPTH];
  logic [6:0] held_w    [LIST_DEPTH];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  // decode of an incoming packet
  assign kind    = status_byte_i[7:4];
  assign is_on   = (kind == KIND_NOTE_ON) && (data_two_i != 7'd0);
  assign is_note = (kind == KIND_NOTE_ON) || (kind == KIND_NOTE_OFF);

  always_comb begin
    if (command_i) begin
      op_in = OP_CMD;
    end else if (!latch_en_q) begin
      op_in = OP_PASS;
    end else if (is_note) begin
      if (toggle_q) begin
        op_in = is_on ? OP_TOGGLE_ON : OP_DROP;
      end else begin
        op_in = is_on ? OP_LATCH_ON : OP_LATCH_OFF;
      end
    end else if (kind == KIND_AFTERTOUCH) begin
      op_in = OP_DROP;
    end else begin
      op_in = OP_PASS;
    end
  end

  assign rel_in = (op_in == OP_CMD) ||
                  ((op_in == OP_LATCH_ON) && (hcount_q == '0) && (lcount_q != '0));

  // scan: the row rotates one cell per step, step k sees entry k at the head
  assign l_in_range = step_q < lcount_q;
  assign h_in_range = step_q < hcount_q;
  assign rel_emit   = rel_q && l_in_range;
  assign scan_go    = (state_q == ST_SCAN) && (!rel_emit || out_free);
  assign scan_last  = step_q == CNT_W'(LIST_DEPTH - 1);
  assign fin_emit   = (state_q == ST_FINISH) && (op_q != OP_LATCH_OFF);
  assign fin_go     = (state_q == ST_FINISH) && (!fin_emit || out_free);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (op_in)
            OP_DROP: state_d = ST_IDLE;
            OP_PASS: state_d = ST_FINISH;
            default: state_d = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_go && scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // list updates at the end of an item
  assign lbase = rel_q ? '0 : lcount_q;
  assign hbase = rel_q ? '0 : hcount_q;

  always_comb begin
    lcount_d = lcount_q;
    hcount_d = hcount_q;
    ap_l     = 1'b0;
    ap_h     = 1'b0;
    rm_l     = 1'b0;
    rm_h     = 1'b0;
    lidx     = lcount_q[IDX_W-1:0];
    hidx     = hcount_q[IDX_W-1:0];
    if (fin_go) begin
      case (op_q)
        OP_CMD: begin
          lcount_d = '0;
          hcount_d = '0;
        end
        OP_LATCH_ON: begin
          lcount_d = lbase;
          hcount_d = hbase;
          lidx     = lbase[IDX_W-1:0];
          hidx     = hbase[IDX_W-1:0];
          if (lbase < CNT_W'(LIST_DEPTH)) begin
            ap_l     = 1'b1;
            lcount_d = lbase + CNT_W'(1);
          end
          if (hbase < CNT_W'(LIST_DEPTH)) begin
            ap_h     = 1'b1;
            hcount_d = hbase + CNT_W'(1);
          end
        end
        OP_LATCH_OFF: begin
          if (hfound_q) begin
            rm_h     = 1'b1;
            hcount_d = hcount_q - CNT_W'(1);
          end else if (!lfound_q && (lcount_q < CNT_W'(LIST_DEPTH))) begin
            ap_l     = 1'b1;
            lcount_d = lcount_q + CNT_W'(1);
          end
        end
        OP_TOGGLE_ON: begin
          if (lfound_q) begin
            rm_l     = 1'b1;
            lcount_d = lcount_q - CNT_W'(1);
          end else if (lcount_q < CNT_W'(LIST_DEPTH)) begin
            ap_l     = 1'b1;
            lcount_d = lcount_q + CNT_W'(1);
          end
        end
        default: begin
          lcount_d = lcount_q;
        end
      endcase
    end
  end

  // output beat
  always_comb begin
    out_load     = 1'b0;
    out_status_d = status_q;
    out_d1_d     = note_q;
    out_d2_d     = vel_q;
    out_last_d   = 1'b1;
    if (scan_go && rel_emit) begin
      out_load     = 1'b1;
      out_status_d = {KIND_NOTE_OFF, relch_q};
      out_d1_d     = latched_w[0];
      out_d2_d     = 7'd0;
      out_last_d   = 1'b0;
    end else if (fin_go && fin_emit) begin
      out_load = 1'b1;
      if ((op_q == OP_TOGGLE_ON) && lfound_q) begin
        out_status_d = {KIND_NOTE_OFF, status_q[3:0]};
        out_d2_d     = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_PASS;
      rel_q       <= 1'b0;
      relch_q     <= 4'd0;
      lcount_q    <= '0;
      hcount_q    <= '0;
      step_q      <= '0;
      lfound_q    <= 1'b0;
      hfound_q    <= 1'b0;
      lpos_q      <= '0;
      hpos_q      <= '0;
      latch_en_q  <= 1'b0;
      toggle_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lcount_q <= lcount_d;
      hcount_q <= hcount_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LATCH_ENABLE: latch_en_q <= cfg_data_i;
          REG_TOGGLE_MODE:  toggle_q   <= cfg_data_i;
          default:          latch_en_q <= latch_en_q;
        endcase
      end
      if (in_accept) begin
        op_q     <= op_in;
        rel_q    <= rel_in;
        step_q   <= '0;
        lfound_q <= 1'b0;
        hfound_q <= 1'b0;
        if ((op_in == OP_LATCH_ON) || (op_in == OP_LATCH_OFF)) begin
          relch_q <= status_byte_i[3:0];
        end
      end else if (scan_go) begin
        step_q <= step_q + CNT_W'(1);
        // first match only, inside the filled part of each list
        if (!lfound_q && l_in_range && (latched_w[0] == note_q)) begin
          lfound_q <= 1'b1;
          lpos_q   <= step_q[IDX_W-1:0];
        end
        if (!hfound_q && h_in_range && (held_w[0] == note_q)) begin
          hfound_q <= 1'b1;
          hpos_q   <= step_q[IDX_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_byte_i;
      note_q   <= data_one_i;
      vel_q    <= data_two_i;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_d1_q     <= out_d1_d;
      out_d2_q     <= out_d2_d;
      out_last_q   <= out_last_d;
    end
  end

  // cell row: a rotation takes from the right neighbor, the head cell wraps
  // to the last cell; a removal shifts every cell from the match position on
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.take_l = scan_go || (rm_l && (IDX_W'(i) >= lpos_q));
    assign ctrl.take_h = scan_go || (rm_h && (IDX_W'(i) >= hpos_q));
    assign ctrl.load_l = ap_l && (lidx == IDX_W'(i));
    assign ctrl.load_h = ap_h && (hidx == IDX_W'(i));

    mnl_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .note_i    (note_q),
      .nbr_l_i   (latched_w[(i + 1) % LIST_DEPTH]),
      .nbr_h_i   (held_w[(i + 1) % LIST_DEPTH]),
      .latched_o (latched_w[i]),
      .held_o    (held_w[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_data_one_o = out_d1_q;
  assign out_data_two_o = out_d2_q;
  assign last_of_run_o  = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/mnl_checker.sv
// port-level checks of the midi note latch, bound to the top level
`default_nettype none

`include "midi_note_latch_core_macros.svh"

module mnl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       command_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_status_o,
  input wire logic [6:0] out_data_one_o,
  input wire logic [6:0] out_data_two_o,
  input wire logic       last_of_run_o
);

  // a release command always runs a list scan, so the input stalls next
  `MNL_ASSERT(a_cmd_stalls, clk_i, rst_ni,
    in_valid_i && !in_stall_o && command_i |=> in_stall_o,
    "release command did not start a scan")

  `MNL_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |-> !out_valid_o,
    "output valid during reset")

  `MNL_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o,
    "stalled output beat dropped")

  `MNL_ASSERT(a_out_stable, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> $stable(out_status_o) && $stable(out_data_one_o) &&
      $stable(out_data_two_o) && $stable(last_of_run_o),
    "stalled output beat changed")

endmodule

bind midi_note_latch_core mnl_checker u_mnl_checker (.*);

`default_nettype wire
